### sv/cham_pkg.sv
// ----------------------------------------------------------------------------
// cham_pkg
// Shared widths, register codes and round functions of the CHAM-64/128
// partial round engine.
// ----------------------------------------------------------------------------
package cham_pkg;

    // Field and bus widths.
    localparam int WORD_W        = 16;
    localparam int BLOCK_W       = 64;
    localparam int KEY_W         = 64;
    localparam int RND_FIELD_W   = 7;
    localparam int TDATA_IN_W    = 80;
    localparam int TDATA_OUT_W   = 64;
    localparam int ADDR_W        = 4;
    localparam int DEF_MAX_ROUND = 127;

    // Round-key store.
    localparam int RK_COUNT = 16;
    localparam int RK_IDX_W = $clog2(RK_COUNT);

    // Register selects, taken from the 8-byte word address.
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Rotation amounts.
    localparam logic [3:0] ROT_ONE     = 4'd1;
    localparam logic [3:0] ROT_EIGHT   = 4'd8;
    localparam logic [3:0] ROT_ELEVEN  = 4'd11;
    localparam logic [3:0] ROT_FIFTEEN = 4'd15;

    // Left rotation of a 16-bit word.
    function automatic logic [WORD_W-1:0] rol16(input logic [WORD_W-1:0] v,
                                                input logic [3:0] r);
        logic [2*WORD_W-1:0] tmp;
        tmp = {v, v} << r;
        return tmp[2*WORD_W-1:WORD_W];
    endfunction

    // Round key at position idx of the schedule, from the 128-bit key.
    function automatic logic [WORD_W-1:0] round_key(input logic [2*KEY_W-1:0] key,
                                                    input logic [RK_IDX_W-1:0] idx);
        logic [2:0]        j;
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] base;
        // The upper half of the schedule sits at (j+8)^1.
        j    = {idx[2:1], idx[0] ^ idx[3]};
        k    = key[WORD_W*j +: WORD_W];
        base = k ^ rol16(k, ROT_ONE);
        if (idx[3])
        begin
            return base ^ rol16(k, ROT_ELEVEN);
        end
        return base ^ rol16(k, ROT_EIGHT);
    endfunction

    // One forward round on state words x,y,z,w (x lowest).
    function automatic logic [BLOCK_W-1:0] round_fwd(input logic [BLOCK_W-1:0] s,
                                                     input logic [WORD_W-1:0] rnd,
                                                     input logic [WORD_W-1:0] rk);
        logic [WORD_W-1:0] yr;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] t;
        yr  = rol16(s[31:16], rnd[0] ? ROT_EIGHT : ROT_ONE);
        sum = (s[15:0] ^ rnd) + (yr ^ rk);
        t   = rol16(sum, rnd[0] ? ROT_ONE : ROT_EIGHT);
        return {t, s[63:16]};
    endfunction

    // One inverse round, undoing round_fwd for the same round index.
    function automatic logic [BLOCK_W-1:0] round_inv(input logic [BLOCK_W-1:0] s,
                                                     input logic [WORD_W-1:0] rnd,
                                                     input logic [WORD_W-1:0] rk);
        logic [WORD_W-1:0] t0;
        logic [WORD_W-1:0] sub;
        logic [WORD_W-1:0] x;
        t0  = rol16(s[63:48], rnd[0] ? ROT_FIFTEEN : ROT_EIGHT);
        sub = rol16(s[15:0], rnd[0] ? ROT_EIGHT : ROT_ONE) ^ rk;
        x   = (t0 - sub) ^ rnd;
        return {s[47:0], x};
    endfunction

endpackage

### sv/cham64_128_partial_round_engine_top.sv
// ----------------------------------------------------------------------------
// cham64_128_partial_round_engine_top
// CHAM-64/128 engine that runs a chosen range of rounds forward or backward.
// ----------------------------------------------------------------------------
// The engine takes one word at a time: a 64-bit state, a direction in tuser
// and a round range, and returns the state after rounds first..stop-1 (or
// their inverses in reverse order). Both round bounds are clamped to
// MAX_ROUND. An accepted word runs its rounds at one round per cycle, each
// fed by one read of the round-key memory, and its state is then handed to
// the output register; an empty range goes to that hand-over at once. No
// new input word is taken before the output register has taken the
// previous result. After reset and after every key register write the
// round-key memory is rebuilt from the key registers, one entry a cycle for
// all 16 entries, and no input word is accepted meanwhile. Key registers
// lie at byte addresses 0 (key_low) and 8 (key_high); only address bit 3
// selects the register.
module cham64_128_partial_round_engine_top
    import cham_pkg::*;
#(
    parameter int MAX_ROUND = DEF_MAX_ROUND
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0: block_in[63:0], first_round[70:64], stop_round[77:71], zero.
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // Bit 0: action.
    input  logic                   s_tuser,
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0: block_out[63:0].
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [KEY_W-1:0]       pwdata,
    output logic [KEY_W-1:0]       prdata,
    output logic                   pready
);

    localparam int RND_W = $clog2(MAX_ROUND + 1);
    localparam int CMP_W = (RND_W > RND_FIELD_W) ? RND_W : RND_FIELD_W;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } eng_state_t;

    eng_state_t           state_reg, state_next;
    logic [BLOCK_W-1:0]   blk_reg, blk_next;
    logic [RND_W-1:0]     round_reg, round_next;
    logic [RND_W-1:0]     left_reg, left_next;
    logic                 dir_reg, dir_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]   out_data_reg, out_data_next;
    logic                 sweep_reg, sweep_next;
    logic [RK_IDX_W-1:0]  sweep_idx_reg, sweep_idx_next;
    logic [KEY_W-1:0]     key_low_reg, key_low_next;
    logic [KEY_W-1:0]     key_high_reg, key_high_next;

    logic [WORD_W-1:0]    rk_mem [RK_COUNT];
    logic [WORD_W-1:0]    rk_rd_reg;
    logic [RK_IDX_W-1:0]  rd_addr;

    logic                 cfg_wr;
    logic                 in_acc;
    logic [RND_W-1:0]     lo, hi;
    logic [CMP_W-1:0]     lo_ext, hi_ext, max_ext;
    logic [RND_W-1:0]     init_round;
    logic [RND_W-1:0]     step_round;
    logic [WORD_W-1:0]    rnd_word;

    // Configuration port: always ready, write on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[3] == REG_KEY_HIGH) ? key_high_reg : key_low_reg;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_wr && paddr[3] == REG_KEY_LOW)
        begin
            key_low_next = pwdata;
        end
        if (cfg_wr && paddr[3] == REG_KEY_HIGH)
        begin
            key_high_next = pwdata;
        end
    end

    // Key schedule sweep: restarts from entry 0 on every key write.
    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        if (cfg_wr)
        begin
            sweep_next     = 1'b1;
            sweep_idx_next = '0;
        end
        else if (sweep_reg)
        begin
            sweep_idx_next = sweep_idx_reg + 1'b1;
            if (sweep_idx_reg == RK_IDX_W'(RK_COUNT - 1))
            begin
                sweep_next = 1'b0;
            end
        end
    end

    // Clamp the round bounds to MAX_ROUND.
    always_comb
    begin
        max_ext = CMP_W'(MAX_ROUND);
        lo_ext  = CMP_W'(s_tdata[70:64]);
        hi_ext  = CMP_W'(s_tdata[77:71]);
        lo      = RND_W'((lo_ext > max_ext) ? max_ext : lo_ext);
        hi      = RND_W'((hi_ext > max_ext) ? max_ext : hi_ext);
        init_round = s_tuser ? (hi - 1'b1) : lo;
    end

    assign s_tready   = (state_reg == ST_IDLE) && !sweep_reg;
    assign in_acc     = s_tvalid & s_tready;
    assign step_round = dir_reg ? (round_reg - 1'b1) : (round_reg + 1'b1);
    assign rnd_word   = WORD_W'(round_reg);

    // Round-key read address: the first round on acceptance, then the next.
    assign rd_addr = in_acc ? init_round[RK_IDX_W-1:0] : step_round[RK_IDX_W-1:0];

    // Round sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        round_next     = round_reg;
        left_next      = left_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    blk_next   = s_tdata[BLOCK_W-1:0];
                    dir_next   = s_tuser;
                    round_next = init_round;
                    left_next  = hi - lo;
                    state_next = (hi > lo) ? ST_RUN : ST_HOLD;
                end
            end
            ST_RUN:
            begin
                blk_next   = dir_reg ? round_inv(blk_reg, rnd_word, rk_rd_reg)
                                     : round_fwd(blk_reg, rnd_word, rk_rd_reg);
                round_next = step_round;
                left_next  = left_reg - 1'b1;
                if (left_reg == RND_W'(1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = blk_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        round_reg    <= round_next;
        left_reg     <= left_next;
        dir_reg      <= dir_next;
        out_data_reg <= out_data_next;
    end

    // Round-key memory: one write port for the sweep, one registered read.
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            rk_mem[sweep_idx_reg] <= round_key({key_high_reg, key_low_reg}, sweep_idx_reg);
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    // No input word is taken while the round-key memory is being rebuilt.
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !s_tready)
        else $error("input accepted during key schedule sweep");

    // The last round hands the state to the output stage.
    a_last_round_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && left_reg == RND_W'(1)) |=> (state_reg == ST_HOLD))
        else $error("sequencer did not finish after the last round");

    // A running item always has rounds left.
    a_run_has_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (left_reg != '0))
        else $error("round counter empty while running");

    // An empty range passes the state through untouched.
    a_empty_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !(hi > lo)) |=> (state_reg == ST_HOLD && blk_reg == $past(s_tdata[63:0])))
        else $error("empty range altered the state");
`endif

endmodule
